### hw/rtl/urd_pkg.sv
`timescale 1ns / 1ps

package urd_pkg;

    // width of the free-running trigger period counter
    localparam int PERIOD_COUNTER_WIDTH = 20;

    // register widths
    localparam int TRIG_PERIOD_W  = 20;
    localparam int TRIG_WIDTH_W   = 16;
    localparam int MUX_PERIOD_W   = 16;
    localparam int TICKS_PER_CM_W = 8;
    localparam int VALUE_W        = 7;
    localparam int UNITS_W        = 8;
    localparam int SEG_W          = 7;
    localparam int DIGIT_W        = 4;

    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    // the period compare runs at the wider of counter and register
    localparam int PERIOD_CMP_W =
        (PERIOD_COUNTER_WIDTH > TRIG_PERIOD_W) ? PERIOD_COUNTER_WIDTH : TRIG_PERIOD_W;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_PERIOD      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_WIDTH       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MUX_PERIOD       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_CM     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SHOWN        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OVER_RANGE_VALUE = 3'd5;

    // reset values
    localparam logic [TRIG_PERIOD_W-1:0]  TRIG_PERIOD_RST      = 20'd100000;
    localparam logic [TRIG_WIDTH_W-1:0]   TRIG_WIDTH_RST       = 16'd1000;
    localparam logic [MUX_PERIOD_W-1:0]   MUX_PERIOD_RST       = 16'd4000;
    localparam logic [TICKS_PER_CM_W-1:0] TICKS_PER_CM_RST     = 8'd58;
    localparam logic [VALUE_W-1:0]        MAX_SHOWN_RST        = 7'd99;
    localparam logic [VALUE_W-1:0]        OVER_RANGE_VALUE_RST = 7'd12;

    localparam logic [UNITS_W-1:0] UNITS_MAX = 8'd255;

    // x * 205 >> 11 is floor(x / 10) for every 7-bit x
    localparam logic [7:0] DIV10_MULT  = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    // seven-segment pattern, bit0 is segment a; codes above nine are blank
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/ultrasonic_ranger_display.sv
`timescale 1ns / 1ps

// channel   direction  tdata fields (lowest bit first)
// s_        in         echo_level[0]
// m_        out        trigger[0] right_select[1] left_select[2] segments[9:3]
//                      shown_value[16:10]
// cfg_      in         cfg_we, cfg_index, cfg_data (plain register write)
//
// one tick beat is taken every cycle; its result beat is in the output register
// the next cycle. all timer state updates in the cycle a tick is accepted.
// a stalled result holds the output register and s_tready drops until it is
// taken. aresetn is synchronous and loads the register defaults, zero state.

module ultrasonic_ranger_display (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [urd_pkg::S_TDATA_W-1:0]        s_tdata,   // echo_level
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // trigger, right_select, left_select, segments, shown_value
    output logic [urd_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                 cfg_we,
    input  logic [urd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [urd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // configuration
    logic [urd_pkg::TRIG_PERIOD_W-1:0]  trig_period_reg;
    logic [urd_pkg::TRIG_WIDTH_W-1:0]   trig_width_reg;
    logic [urd_pkg::MUX_PERIOD_W-1:0]   mux_period_reg;
    logic [urd_pkg::TICKS_PER_CM_W-1:0] ticks_per_cm_reg;
    logic [urd_pkg::VALUE_W-1:0]        max_shown_reg;
    logic [urd_pkg::VALUE_W-1:0]        over_range_value_reg;

    // timer state
    logic [urd_pkg::PERIOD_COUNTER_WIDTH-1:0] trig_period_count_reg, trig_period_count_next;
    logic [urd_pkg::TRIG_WIDTH_W-1:0]         trig_high_count_reg, trig_high_count_next;
    logic [urd_pkg::MUX_PERIOD_W-1:0]         mux_count_reg, mux_count_next;
    logic                                     echo_prev_reg;
    logic [urd_pkg::TICKS_PER_CM_W-1:0]       echo_prescale_reg, echo_prescale_next;
    logic [urd_pkg::UNITS_W-1:0]              echo_units_reg, echo_units_next;
    logic [urd_pkg::UNITS_W-1:0]              distance_reg, distance_next;
    logic                                     right_active_reg, right_active_next;
    logic [urd_pkg::VALUE_W-1:0]              shown_reg, shown_next;

    // output register
    logic                          m_valid_reg;
    logic [urd_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                                     accept;
    logic                                     echo;
    logic                                     trig;
    logic [urd_pkg::PERIOD_COUNTER_WIDTH-1:0] period_inc;
    logic [urd_pkg::TRIG_WIDTH_W-1:0]         high_loaded;
    logic [urd_pkg::TICKS_PER_CM_W-1:0]       prescale_base, prescale_inc;
    logic [urd_pkg::UNITS_W-1:0]              units_base;
    logic [urd_pkg::MUX_PERIOD_W-1:0]         mux_inc;
    logic [14:0]                              div_prod;
    logic [urd_pkg::DIGIT_W-1:0]              tens, ones, digit;
    logic [urd_pkg::VALUE_W-1:0]              tens_x10;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign echo     = s_tdata[0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        // trigger generation
        period_inc  = trig_period_count_reg + 1'b1;
        high_loaded = trig_high_count_reg;
        trig_period_count_next = period_inc;
        if (urd_pkg::PERIOD_CMP_W'(period_inc) >= urd_pkg::PERIOD_CMP_W'(trig_period_reg)) begin
            trig_period_count_next = '0;
            high_loaded = trig_width_reg;
        end
        trig = (high_loaded != '0);
        trig_high_count_next = trig ? high_loaded - 1'b1 : high_loaded;

        // echo pulse timing, a rising edge restarts the count
        prescale_base = echo_prescale_reg;
        units_base    = echo_units_reg;
        if (echo && !echo_prev_reg) begin
            prescale_base = '0;
            units_base    = '0;
        end
        prescale_inc       = prescale_base + 1'b1;
        echo_prescale_next = prescale_base;
        echo_units_next    = units_base;
        distance_next      = distance_reg;
        if (echo) begin
            echo_prescale_next = prescale_inc;
            if (prescale_inc >= ticks_per_cm_reg) begin
                echo_prescale_next = '0;
                if (units_base != urd_pkg::UNITS_MAX) begin
                    echo_units_next = units_base + 1'b1;
                end
            end
        end else if (echo_prev_reg) begin
            distance_next = echo_units_reg;
        end

        // display refresh sees the distance of this tick
        mux_inc           = mux_count_reg + 1'b1;
        mux_count_next    = mux_inc;
        right_active_next = right_active_reg;
        shown_next        = shown_reg;
        if (mux_inc >= mux_period_reg) begin
            mux_count_next    = '0;
            right_active_next = !right_active_reg;
            if (distance_next > urd_pkg::UNITS_W'(max_shown_reg)) begin
                shown_next = over_range_value_reg;
            end else begin
                shown_next = distance_next[urd_pkg::VALUE_W-1:0];
            end
        end

        // split into tens and ones by reciprocal multiply
        div_prod = 15'(shown_next) * 15'(urd_pkg::DIV10_MULT);
        tens     = div_prod[14:urd_pkg::DIV10_SHIFT];
        tens_x10 = urd_pkg::VALUE_W'({tens, 3'b000}) + urd_pkg::VALUE_W'({tens, 1'b0});
        ones     = urd_pkg::DIGIT_W'(shown_next - tens_x10);
        digit    = right_active_next ? ones : tens;

        m_data_next = '0;
        m_data_next[0]     = trig;
        m_data_next[1]     = right_active_next;
        m_data_next[2]     = !right_active_next;
        m_data_next[9:3]   = urd_pkg::seg_of(digit);
        m_data_next[16:10] = shown_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_period_reg      <= urd_pkg::TRIG_PERIOD_RST;
            trig_width_reg       <= urd_pkg::TRIG_WIDTH_RST;
            mux_period_reg       <= urd_pkg::MUX_PERIOD_RST;
            ticks_per_cm_reg     <= urd_pkg::TICKS_PER_CM_RST;
            max_shown_reg        <= urd_pkg::MAX_SHOWN_RST;
            over_range_value_reg <= urd_pkg::OVER_RANGE_VALUE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                urd_pkg::REG_TRIG_PERIOD:
                    trig_period_reg <= cfg_data[urd_pkg::TRIG_PERIOD_W-1:0];
                urd_pkg::REG_TRIG_WIDTH:
                    trig_width_reg <= cfg_data[urd_pkg::TRIG_WIDTH_W-1:0];
                urd_pkg::REG_MUX_PERIOD:
                    mux_period_reg <= cfg_data[urd_pkg::MUX_PERIOD_W-1:0];
                urd_pkg::REG_TICKS_PER_CM:
                    ticks_per_cm_reg <= cfg_data[urd_pkg::TICKS_PER_CM_W-1:0];
                urd_pkg::REG_MAX_SHOWN:
                    max_shown_reg <= cfg_data[urd_pkg::VALUE_W-1:0];
                urd_pkg::REG_OVER_RANGE_VALUE:
                    over_range_value_reg <= cfg_data[urd_pkg::VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_period_count_reg <= '0;
            trig_high_count_reg   <= '0;
            mux_count_reg         <= '0;
            echo_prev_reg         <= 1'b0;
            echo_prescale_reg     <= '0;
            echo_units_reg        <= '0;
            distance_reg          <= '0;
            right_active_reg      <= 1'b0;
            shown_reg             <= '0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (accept) begin
                trig_period_count_reg <= trig_period_count_next;
                trig_high_count_reg   <= trig_high_count_next;
                mux_count_reg         <= mux_count_next;
                echo_prev_reg         <= echo;
                echo_prescale_reg     <= echo_prescale_next;
                echo_units_reg        <= echo_units_next;
                distance_reg          <= distance_next;
                right_active_reg      <= right_active_next;
                shown_reg             <= shown_next;
                m_valid_reg           <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload, loaded only with a new tick
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
